// ===== rtl/core/fbpa_pkg.sv =====
// shared constants, command and status types for the free block pool allocator
package fbpa_pkg;

    localparam int CHIPS           = 4;
    localparam int BLOCKS_PER_CHIP = 256;
    localparam int PLANES          = 2;

    localparam int NQ           = CHIPS * PLANES;
    localparam int QDEPTH       = (BLOCKS_PER_CHIP + PLANES - 1) / PLANES;
    localparam int TOTAL_BLOCKS = CHIPS * BLOCKS_PER_CHIP;

    // port field widths
    localparam int OPW = 2;
    localparam int QSW = 3;
    localparam int BW  = 10;
    localparam int STW = 2;
    localparam int TW  = 11;

    localparam int QW  = (NQ > 1) ? $clog2(NQ) : 1;
    localparam int PW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW  = $clog2(QDEPTH + 1);
    localparam int AW  = QW + PW;
    localparam int CHW = (CHIPS > 1) ? $clog2(CHIPS) : 1;
    localparam int PLW = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int OFW = $clog2(BLOCKS_PER_CHIP);
    localparam int FVW = $clog2(TOTAL_BLOCKS + (2 ** PW) * PLANES + 1);

    // reciprocal for the plane remainder of an offset within a chip
    localparam int RSH   = 16;
    localparam int RCW   = RSH + 1;
    localparam int RECIP = ((2 ** RSH) + PLANES - 1) / PLANES;

    localparam logic [OPW-1:0] OP_ALLOC_ANY  = 2'd0;
    localparam logic [OPW-1:0] OP_ALLOC_CHIP = 2'd1;
    localparam logic [OPW-1:0] OP_RELEASE    = 2'd2;

    localparam logic [STW-1:0] ST_OK       = 2'd0;
    localparam logic [STW-1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [STW-1:0] ST_REJECT   = 2'd2;

    typedef struct packed {
        logic fill;
        logic load;
        logic decode;
        logic pick;
        logic access;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_last;
    } t_dp_stat;

    function automatic logic [CW-1:0] init_count(input int q);
        int plane;
        int n;
        plane = q / CHIPS;
        n = (BLOCKS_PER_CHIP - plane + PLANES - 1) / PLANES;
        if (q == 0) begin
            n = n - 1;
        end
        return CW'(n);
    endfunction

    function automatic logic [PW-1:0] init_tail(input int q);
        return PW'(int'(init_count(q)) % QDEPTH);
    endfunction

endpackage

// ===== rtl/core/fbpa_ctrl.sv =====
// sequencing state machine: initial fill sweep, then decode, pick, access, reply per item
module fbpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    output logic               o_done,
    output fbpa_pkg::t_dp_cmd  o_cmd,
    input  fbpa_pkg::t_dp_stat i_stat
);
    import fbpa_pkg::*;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_DECODE,
        S_PICK,
        S_ACCESS,
        S_REPLY
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FILL: begin
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: n_state = S_PICK;
            S_PICK:   n_state = S_ACCESS;
            S_ACCESS: n_state = S_REPLY;
            S_REPLY:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (n_state == S_REPLY);
        end
    end

    always_comb begin
        o_cmd.fill   = (r_state == S_FILL);
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.decode = (r_state == S_DECODE);
        o_cmd.pick   = (r_state == S_PICK);
        o_cmd.access = (r_state == S_ACCESS);
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// ===== rtl/core/fbpa_dp.sv =====
// queue store, per-queue pointers and counts, queue selection and result registers
module fbpa_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fbpa_pkg::t_dp_cmd            i_cmd,
    output fbpa_pkg::t_dp_stat           o_stat,
    input  logic [fbpa_pkg::OPW-1:0]     i_opcode,
    input  logic [fbpa_pkg::QSW-1:0]     i_queue_select,
    input  logic [fbpa_pkg::BW-1:0]      i_block_number,
    output logic [fbpa_pkg::STW-1:0]     o_status,
    output logic [fbpa_pkg::BW-1:0]      o_granted_block,
    output logic [fbpa_pkg::TW-1:0]      o_free_total
);
    import fbpa_pkg::*;

    logic [BW-1:0]  mem [2 ** AW];

    // item registers
    logic [OPW-1:0] r_op;
    logic [QSW-1:0] r_qsel;
    logic [BW-1:0]  r_blk;
    logic [CHW-1:0] r_chip;
    logic [OFW-1:0] r_within;
    logic           r_in_range;
    logic [QW-1:0]  r_q;
    logic           r_found;
    logic [STW-1:0] r_status;
    logic           r_grant_ok;
    logic [BW-1:0]  r_rdata;

    // queue state
    logic [PW-1:0]  r_head  [NQ];
    logic [PW-1:0]  r_tail  [NQ];
    logic [CW-1:0]  r_count [NQ];
    logic [TW-1:0]  r_total;
    logic [QW-1:0]  r_rr;

    // initial fill sweep
    logic [QW-1:0]  r_fq;
    logic [PW-1:0]  r_fk;
    logic [CHW-1:0] r_fchip;
    logic [PLW-1:0] r_fplane;
    logic [FVW-1:0] r_fbase;
    logic [FVW-1:0] r_fval;

    logic [NQ-1:0]  nz;

    logic [CHW-1:0] d_chip;
    logic [31:0]    d_base;
    logic [OFW-1:0] d_within;
    logic           d_in_range;

    logic [OFW+RCW-1:0] rel_prod;
    logic [OFW-1:0]     rel_quot;
    logic [OFW-1:0]     rel_rem;
    logic [QW-1:0]      rel_q;

    logic           any_found;
    logic [QW-1:0]  any_q;
    logic           sel_valid;
    logic [CHW-1:0] sel_chip;
    logic [PLW-1:0] sel_plane;
    logic           chip_found;
    logic [QW-1:0]  chip_q;
    logic           p_found;
    logic [QW-1:0]  p_q;

    logic           is_alloc;
    logic           a_full;
    logic           do_pop;
    logic           do_push;
    logic           m_we;
    logic [AW-1:0]  m_waddr;
    logic [BW-1:0]  m_wdata;
    logic [AW-1:0]  m_raddr;
    logic [STW-1:0] a_status;

    always_comb begin
        for (int j = 0; j < NQ; j++) begin
            nz[j] = (r_count[j] != '0);
        end
    end

    // chip and offset of a released block
    always_comb begin
        d_chip = '0;
        d_base = '0;
        for (int c = 1; c < CHIPS; c++) begin
            if (32'(r_blk) >= 32'(c * BLOCKS_PER_CHIP)) begin
                d_chip = CHW'(c);
                d_base = 32'(c * BLOCKS_PER_CHIP);
            end
        end
        d_within   = OFW'(32'(r_blk) - d_base);
        d_in_range = (32'(r_blk) < 32'(TOTAL_BLOCKS));
    end

    // plane of a released block: offset modulo planes
    always_comb begin
        rel_prod = (OFW + RCW)'(r_within) * (OFW + RCW)'(RECIP);
        rel_quot = rel_prod[RSH +: OFW];
        rel_rem  = r_within - OFW'(32'(rel_quot) * PLANES);
        if (32'(rel_rem) >= PLANES) begin
            rel_rem = rel_rem - OFW'(PLANES);
        end
        rel_q = QW'(32'(rel_rem) * CHIPS + 32'(r_chip));
    end

    // round robin: first non-empty queue from the pointer on
    always_comb begin
        int qi;
        any_found = 1'b0;
        any_q     = '0;
        for (int i = NQ - 1; i >= 0; i--) begin
            qi = 32'(r_rr) + i;
            if (qi >= NQ) begin
                qi = qi - NQ;
            end
            if (nz[QW'(qi)]) begin
                any_found = 1'b1;
                any_q     = QW'(qi);
            end
        end
    end

    // in-chip: named plane first, then the chip's other planes, wrapping
    always_comb begin
        int pi;
        int qc;
        sel_valid = 1'b0;
        sel_chip  = '0;
        sel_plane = '0;
        for (int j = 0; j < NQ; j++) begin
            if (32'(r_qsel) == j) begin
                sel_valid = 1'b1;
                sel_chip  = CHW'(j % CHIPS);
                sel_plane = PLW'(j / CHIPS);
            end
        end
        chip_found = 1'b0;
        chip_q     = '0;
        for (int i = PLANES - 1; i >= 0; i--) begin
            pi = 32'(sel_plane) + i;
            if (pi >= PLANES) begin
                pi = pi - PLANES;
            end
            qc = pi * CHIPS + 32'(sel_chip);
            if (nz[QW'(qc)]) begin
                chip_found = 1'b1;
                chip_q     = QW'(qc);
            end
        end
        chip_found = chip_found && sel_valid;
    end

    always_comb begin
        case (r_op)
            OP_ALLOC_ANY: begin
                p_found = any_found;
                p_q     = any_q;
            end
            OP_ALLOC_CHIP: begin
                p_found = chip_found;
                p_q     = chip_q;
            end
            OP_RELEASE: begin
                p_found = r_in_range;
                p_q     = rel_q;
            end
            default: begin
                p_found = 1'b0;
                p_q     = '0;
            end
        endcase
    end

    always_comb begin
        is_alloc = (r_op == OP_ALLOC_ANY) || (r_op == OP_ALLOC_CHIP);
        a_full   = (r_count[r_q] >= CW'(QDEPTH));
        do_pop   = i_cmd.access && is_alloc && r_found;
        do_push  = i_cmd.access && (r_op == OP_RELEASE) && r_found && !a_full;
        m_we     = i_cmd.fill || do_push;
        m_waddr  = i_cmd.fill ? {r_fq, r_fk} : {r_q, r_tail[r_q]};
        m_wdata  = i_cmd.fill ? BW'(r_fval) : r_blk;
        m_raddr  = {r_q, r_head[r_q]};
        case (r_op)
            OP_ALLOC_ANY, OP_ALLOC_CHIP: a_status = r_found ? ST_OK : ST_NO_BLOCK;
            OP_RELEASE:                  a_status = (r_found && !a_full) ? ST_OK : ST_REJECT;
            default:                     a_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem[m_waddr] <= m_wdata;
        end
        if (do_pop) begin
            r_rdata <= mem[m_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_qsel <= i_queue_select;
            r_blk  <= i_block_number;
        end
        if (i_cmd.decode) begin
            r_chip     <= d_chip;
            r_within   <= d_within;
            r_in_range <= d_in_range;
        end
        if (i_cmd.pick) begin
            r_q     <= p_q;
            r_found <= p_found;
        end
        if (i_cmd.access) begin
            r_status   <= a_status;
            r_grant_ok <= is_alloc && r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NQ; q++) begin
                r_head[q]  <= '0;
                r_tail[q]  <= init_tail(q);
                r_count[q] <= init_count(q);
            end
            r_total  <= TW'(TOTAL_BLOCKS - 1);
            r_rr     <= '0;
            r_fq     <= '0;
            r_fk     <= '0;
            r_fchip  <= '0;
            r_fplane <= '0;
            r_fbase  <= '0;
            // block 0 stays out of the pool, so queue 0 starts one step on
            r_fval   <= FVW'(PLANES);
        end else begin
            if (i_cmd.fill) begin
                if (r_fk == '1) begin
                    r_fk <= '0;
                    r_fq <= r_fq + 1'b1;
                    if (r_fchip == CHW'(CHIPS - 1)) begin
                        r_fchip  <= '0;
                        r_fplane <= r_fplane + 1'b1;
                        r_fbase  <= '0;
                        r_fval   <= FVW'(32'(r_fplane) + 1);
                    end else begin
                        r_fchip <= r_fchip + 1'b1;
                        r_fbase <= r_fbase + FVW'(BLOCKS_PER_CHIP);
                        r_fval  <= r_fbase + FVW'(BLOCKS_PER_CHIP) + FVW'(r_fplane);
                    end
                end else begin
                    r_fk   <= r_fk + 1'b1;
                    r_fval <= r_fval + FVW'(PLANES);
                end
            end
            if (do_pop) begin
                r_head[r_q]  <= (r_head[r_q] == PW'(QDEPTH - 1)) ? '0 : r_head[r_q] + 1'b1;
                r_count[r_q] <= r_count[r_q] - 1'b1;
                r_total      <= r_total - 1'b1;
                if (r_op == OP_ALLOC_ANY) begin
                    r_rr <= (r_q == QW'(NQ - 1)) ? '0 : r_q + 1'b1;
                end
            end
            if (do_push) begin
                r_tail[r_q]  <= (r_tail[r_q] == PW'(QDEPTH - 1)) ? '0 : r_tail[r_q] + 1'b1;
                r_count[r_q] <= r_count[r_q] + 1'b1;
                r_total      <= r_total + 1'b1;
            end
        end
    end

    assign o_stat.fill_last = (r_fq == QW'(NQ - 1)) && (r_fk == '1);

    assign o_status        = r_status;
    assign o_granted_block = r_grant_ok ? r_rdata : '0;
    assign o_free_total    = r_total;

endmodule

// ===== rtl/core/free_block_pool_allocator.sv =====
// free block pool allocator: per chip and plane queues of free flash blocks
// an accepted item steps through decode, pick, access and reply; o_done rises with the reply step
// a new item is taken only in idle, once the four sequencing steps of the last one are done
// the result shows for one cycle on o_done; the receiver cannot stall
// after reset busy stays high while the queue store is filled with every block except block 0,
// ascending within each queue; reset is synchronous, active low
module free_block_pool_allocator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [fbpa_pkg::OPW-1:0] i_opcode,
    input  logic [fbpa_pkg::QSW-1:0] i_queue_select,
    input  logic [fbpa_pkg::BW-1:0]  i_block_number,
    output logic                     o_done,
    output logic [fbpa_pkg::STW-1:0] o_status,
    output logic [fbpa_pkg::BW-1:0]  o_granted_block,
    output logic [fbpa_pkg::TW-1:0]  o_free_total
);
    import fbpa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    fbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    fbpa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_queue_select  (i_queue_select),
        .i_block_number  (i_block_number),
        .o_status        (o_status),
        .o_granted_block (o_granted_block),
        .o_free_total    (o_free_total)
    );

endmodule
